[rtl/core/sfn_pkg.sv]
// Package for the sub-cell front and normal block: payload types, widths and constants.
package sfn_pkg;

    localparam int COORD_BITS = 10;
    localparam int DEN_W      = 32;
    localparam int MAG_W      = 34;
    localparam int SUM_W      = MAG_W + 1;
    localparam int HALF_W     = MAG_W / 2;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SS_W       = SQ_W + 2;
    localparam int REM_W      = SS_W + 2;
    localparam int ROOT_W     = SS_W / 2;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int Q_W        = 15;
    localparam int DV_STEPS   = Q_W;
    localparam int DIV_W      = ROOT_W + 1;
    localparam int NUM_W      = MAG_W + Q_W + 2;
    localparam int NML_W      = 16;
    localparam int CFG_W      = 32;

    localparam logic [NML_W-1:0] NML_ONE = 16'd16384;

    localparam logic CFG_SOLID = 1'b0;
    localparam logic CFG_MIN   = 1'b1;

    typedef struct packed {
        logic [DEN_W-1:0]      density_0;
        logic [DEN_W-1:0]      density_1;
        logic [DEN_W-1:0]      density_2;
        logic [DEN_W-1:0]      density_3;
        logic [DEN_W-1:0]      density_4;
        logic [DEN_W-1:0]      density_5;
        logic [DEN_W-1:0]      density_6;
        logic [DEN_W-1:0]      density_7;
        logic [COORD_BITS-1:0] cell_x;
        logic [COORD_BITS-1:0] cell_y;
        logic [COORD_BITS-1:0] cell_z;
        logic [2:0]            sub_index;
    } t_in;

    typedef struct packed {
        logic                    is_front;
        logic signed [NML_W-1:0] normal_x;
        logic signed [NML_W-1:0] normal_y;
        logic signed [NML_W-1:0] normal_z;
        logic [COORD_BITS-1:0]   front_x;
        logic [COORD_BITS-1:0]   front_y;
        logic [COORD_BITS-1:0]   front_z;
        logic [2:0]              front_sub;
    } t_out;

    typedef struct packed {
        logic                  front;
        logic                  dflt;
        logic [2:0]            neg;
        logic [MAG_W-1:0]      mag_x;
        logic [MAG_W-1:0]      mag_y;
        logic [MAG_W-1:0]      mag_z;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
        logic [2:0]            sub;
    } t_side;

endpackage

[rtl/core/subcell_front_normal.sv]
// Sub-cell surface front test and normalized corner-difference gradient.
//
//  port group | direction | handshake              | payload
//  -----------+-----------+------------------------+-----------------------
//  in         | input     | i_in_valid/o_in_ready  | i_in_data   (t_in)
//  out        | output    | o_out_valid/i_out_ready| o_out_data  (t_out)
//  cfg        | input     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
//  One item per cycle while the output is not stalled; 58 register stages: 6
//  gradient/square stages, 35 square-root stages (one root bit each), 16 divider
//  stages (seed, then one quotient bit each, three lanes) and the output.
//  Reset clears all valid bits and loads the register defaults.
//  A stall at the output freezes the whole pipeline; o_in_ready drops with it.
module subcell_front_normal
    import sfn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_solid;
    logic [CFG_W-1:0] r_min;

    logic en;

    logic [DEN_W-1:0] d [8];

    // stage 1
    logic                    r1_v;
    t_side                   r1_sd;
    logic signed [SUM_W-1:0] r1_g [3];
    // stage 2
    logic                    r2_v;
    t_side                   r2_sd;
    // stage 3
    logic                    r3_v;
    t_side                   r3_sd;
    logic [2*HALF_W-1:0]     r3_hh [3];
    logic [2*HALF_W-1:0]     r3_hl [3];
    logic [2*HALF_W-1:0]     r3_ll [3];
    logic [2*CFG_W-1:0]      r3_lim;
    // stage 4
    logic                    r4_v;
    t_side                   r4_sd;
    logic [SQ_W-1:0]         r4_sq [3];
    logic [2*CFG_W-1:0]      r4_lim;
    // stage 5
    logic                    r5_v;
    t_side                   r5_sd;
    logic [SS_W-1:0]         r5_s;
    logic [2*CFG_W-1:0]      r5_lim;
    // square root
    logic                    r_sq_v    [SQ_STEPS+1];
    t_side                   r_sq_sd   [SQ_STEPS+1];
    logic [REM_W-1:0]        r_sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]       r_sq_root [SQ_STEPS+1];
    logic [REM_W-1:0]        n_sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]       n_sq_root [SQ_STEPS+1];
    // divider
    logic                    r_dv_v   [DV_STEPS+1];
    t_side                   r_dv_sd  [DV_STEPS+1];
    logic [DIV_W-1:0]        r_dv_d   [DV_STEPS+1];
    logic [NUM_W-1:0]        r_dv_rem [DV_STEPS+1][3];
    logic [Q_W-1:0]          r_dv_q   [DV_STEPS+1][3];
    logic [NUM_W-1:0]        n_dv_rem [DV_STEPS+1][3];
    logic [Q_W-1:0]          n_dv_q   [DV_STEPS+1][3];
    // output
    logic                    r_ov;
    t_out                    r_out;

    logic [3:0]              n_cnt;
    logic [MAG_W-1:0]        a_sum [3];
    logic [MAG_W-1:0]        b_sum [3];
    logic signed [SUM_W-1:0] n_neg_g [3];
    logic [MAG_W-1:0]        n_mag [3];
    logic [NML_W-1:0]        n_q [3];
    logic signed [NML_W-1:0] n_nml [3];
    logic [MAG_W-1:0]        mag_in [3];
    logic [REM_W-1:0]        sq_trial;
    logic [NUM_W-1:0]        dv_trial;
    t_side                   n1_sd;
    t_side                   n2_sd;
    t_side                   n_sq_sd0;
    t_out                    n_out;

    assign en          = !r_ov || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign d[0] = i_in_data.density_0;
    assign d[1] = i_in_data.density_1;
    assign d[2] = i_in_data.density_2;
    assign d[3] = i_in_data.density_3;
    assign d[4] = i_in_data.density_4;
    assign d[5] = i_in_data.density_5;
    assign d[6] = i_in_data.density_6;
    assign d[7] = i_in_data.density_7;

    always_comb begin
        n_cnt = '0;
        for (int u = 0; u < 8; u++) begin
            n_cnt = n_cnt + {3'b0, (d[u] > r_solid)};
        end
        a_sum[0] = MAG_W'(d[1]) + MAG_W'(d[3]) + MAG_W'(d[5]) + MAG_W'(d[7]);
        b_sum[0] = MAG_W'(d[0]) + MAG_W'(d[2]) + MAG_W'(d[4]) + MAG_W'(d[6]);
        a_sum[1] = MAG_W'(d[2]) + MAG_W'(d[3]) + MAG_W'(d[6]) + MAG_W'(d[7]);
        b_sum[1] = MAG_W'(d[0]) + MAG_W'(d[1]) + MAG_W'(d[4]) + MAG_W'(d[5]);
        a_sum[2] = MAG_W'(d[4]) + MAG_W'(d[5]) + MAG_W'(d[6]) + MAG_W'(d[7]);
        b_sum[2] = MAG_W'(d[0]) + MAG_W'(d[1]) + MAG_W'(d[2]) + MAG_W'(d[3]);
        n1_sd       = '0;
        n1_sd.front = (n_cnt != 4'd0) && (n_cnt != 4'd8);
        n1_sd.cx    = i_in_data.cell_x;
        n1_sd.cy    = i_in_data.cell_y;
        n1_sd.cz    = i_in_data.cell_z;
        n1_sd.sub   = i_in_data.sub_index;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_neg_g[c] = -r1_g[c];
            n_mag[c]   = r1_g[c][SUM_W-1] ? n_neg_g[c][MAG_W-1:0] : r1_g[c][MAG_W-1:0];
        end
        n2_sd       = r1_sd;
        n2_sd.neg   = {r1_g[2][SUM_W-1], r1_g[1][SUM_W-1], r1_g[0][SUM_W-1]};
        n2_sd.mag_x = n_mag[0];
        n2_sd.mag_y = n_mag[1];
        n2_sd.mag_z = n_mag[2];
        n_sq_sd0      = r5_sd;
        n_sq_sd0.dflt = r5_s <= {{(SS_W-2*CFG_W){1'b0}}, r5_lim};
    end

    // root bit b = SQ_STEPS - k, remainder holds s - root^2
    always_comb begin
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
        sq_trial     = '0;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            sq_trial = ({{(REM_W-ROOT_W){1'b0}}, r_sq_root[k-1]} << (SQ_STEPS - k + 1))
                     + ({{(REM_W-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - k)));
            if (r_sq_rem[k-1] >= sq_trial) begin
                n_sq_rem[k]  = r_sq_rem[k-1] - sq_trial;
                n_sq_root[k] = r_sq_root[k-1] | ({{(ROOT_W-1){1'b0}}, 1'b1} << (SQ_STEPS - k));
            end else begin
                n_sq_rem[k]  = r_sq_rem[k-1];
                n_sq_root[k] = r_sq_root[k-1];
            end
        end
    end

    // quotient bit i = DV_STEPS - j
    always_comb begin
        dv_trial = '0;
        for (int c = 0; c < 3; c++) begin
            n_dv_rem[0][c] = '0;
            n_dv_q[0][c]   = '0;
        end
        for (int j = 1; j <= DV_STEPS; j++) begin
            dv_trial = {{(NUM_W-DIV_W){1'b0}}, r_dv_d[j-1]} << (DV_STEPS - j);
            for (int c = 0; c < 3; c++) begin
                if (r_dv_rem[j-1][c] >= dv_trial) begin
                    n_dv_rem[j][c] = r_dv_rem[j-1][c] - dv_trial;
                    n_dv_q[j][c]   = r_dv_q[j-1][c] | ({{(Q_W-1){1'b0}}, 1'b1} << (DV_STEPS - j));
                end else begin
                    n_dv_rem[j][c] = r_dv_rem[j-1][c];
                    n_dv_q[j][c]   = r_dv_q[j-1][c];
                end
            end
        end
    end

    always_comb begin
        mag_in[0] = r_sq_sd[SQ_STEPS].mag_x;
        mag_in[1] = r_sq_sd[SQ_STEPS].mag_y;
        mag_in[2] = r_sq_sd[SQ_STEPS].mag_z;
        for (int c = 0; c < 3; c++) begin
            n_q[c] = ({1'b0, r_dv_q[DV_STEPS][c]} > NML_ONE) ? NML_ONE
                   : {1'b0, r_dv_q[DV_STEPS][c]};
            n_nml[c] = r_dv_sd[DV_STEPS].neg[c] ? -$signed(n_q[c]) : $signed(n_q[c]);
        end
        n_out.is_front  = r_dv_sd[DV_STEPS].front;
        n_out.front_x   = r_dv_sd[DV_STEPS].cx;
        n_out.front_y   = r_dv_sd[DV_STEPS].cy;
        n_out.front_z   = r_dv_sd[DV_STEPS].cz;
        n_out.front_sub = r_dv_sd[DV_STEPS].sub;
        if (!r_dv_sd[DV_STEPS].front) begin
            n_out.normal_x = '0;
            n_out.normal_y = '0;
            n_out.normal_z = '0;
        end else if (r_dv_sd[DV_STEPS].dflt) begin
            n_out.normal_x = '0;
            n_out.normal_y = NML_ONE;
            n_out.normal_z = '0;
        end else begin
            n_out.normal_x = n_nml[0];
            n_out.normal_y = n_nml[1];
            n_out.normal_z = n_nml[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid <= 32'd4;
            r_min   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOLID: r_solid <= i_cfg_data;
                CFG_MIN:   r_min   <= i_cfg_data;
                default:   r_solid <= r_solid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_sq_v[k] <= 1'b0;
            for (int j = 0; j <= DV_STEPS; j++) r_dv_v[j] <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r_sq_v[0] <= r5_v;
            for (int k = 1; k <= SQ_STEPS; k++) r_sq_v[k] <= r_sq_v[k-1];
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
            for (int j = 1; j <= DV_STEPS; j++) r_dv_v[j] <= r_dv_v[j-1];
            r_ov <= r_dv_v[DV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // gradient and front test
            r1_sd <= n1_sd;
            for (int c = 0; c < 3; c++) begin
                r1_g[c] <= $signed({1'b0, a_sum[c]}) - $signed({1'b0, b_sum[c]});
            end
            // magnitudes
            r2_sd <= n2_sd;
            // partial products
            r3_sd  <= r2_sd;
            r3_lim <= 64'(r_min) * 64'(r_min);
            r3_hh[0] <= r2_sd.mag_x[MAG_W-1:HALF_W] * r2_sd.mag_x[MAG_W-1:HALF_W];
            r3_hl[0] <= r2_sd.mag_x[MAG_W-1:HALF_W] * r2_sd.mag_x[HALF_W-1:0];
            r3_ll[0] <= r2_sd.mag_x[HALF_W-1:0] * r2_sd.mag_x[HALF_W-1:0];
            r3_hh[1] <= r2_sd.mag_y[MAG_W-1:HALF_W] * r2_sd.mag_y[MAG_W-1:HALF_W];
            r3_hl[1] <= r2_sd.mag_y[MAG_W-1:HALF_W] * r2_sd.mag_y[HALF_W-1:0];
            r3_ll[1] <= r2_sd.mag_y[HALF_W-1:0] * r2_sd.mag_y[HALF_W-1:0];
            r3_hh[2] <= r2_sd.mag_z[MAG_W-1:HALF_W] * r2_sd.mag_z[MAG_W-1:HALF_W];
            r3_hl[2] <= r2_sd.mag_z[MAG_W-1:HALF_W] * r2_sd.mag_z[HALF_W-1:0];
            r3_ll[2] <= r2_sd.mag_z[HALF_W-1:0] * r2_sd.mag_z[HALF_W-1:0];
            // squares
            r4_sd  <= r3_sd;
            r4_lim <= r3_lim;
            for (int c = 0; c < 3; c++) begin
                r4_sq[c] <= {r3_hh[c], {(2*HALF_W){1'b0}}}
                          + {{(HALF_W-1){1'b0}}, r3_hl[c], {(HALF_W+1){1'b0}}}
                          + {{(2*HALF_W){1'b0}}, r3_ll[c]};
            end
            // sum of squares
            r5_sd  <= r4_sd;
            r5_lim <= r4_lim;
            r5_s   <= {2'b0, r4_sq[0]} + {2'b0, r4_sq[1]} + {2'b0, r4_sq[2]};
            // length test, root seed
            r_sq_sd[0]   <= n_sq_sd0;
            r_sq_rem[0]  <= {{(REM_W-SS_W){1'b0}}, r5_s};
            r_sq_root[0] <= '0;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_sq_sd[k]   <= r_sq_sd[k-1];
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
            end
            // divider seed: (m*32768 + len) / (2*len)
            r_dv_sd[0] <= r_sq_sd[SQ_STEPS];
            r_dv_d[0]  <= {r_sq_root[SQ_STEPS], 1'b0};
            for (int c = 0; c < 3; c++) begin
                r_dv_rem[0][c] <= {2'b0, mag_in[c], {Q_W{1'b0}}}
                                + {{(NUM_W-ROOT_W){1'b0}}, r_sq_root[SQ_STEPS]};
                r_dv_q[0][c]   <= '0;
            end
            for (int j = 1; j <= DV_STEPS; j++) begin
                r_dv_sd[j] <= r_dv_sd[j-1];
                r_dv_d[j]  <= r_dv_d[j-1];
                for (int c = 0; c < 3; c++) begin
                    r_dv_rem[j][c] <= n_dv_rem[j][c];
                    r_dv_q[j][c]   <= n_dv_q[j][c];
                end
            end
            // result
            r_out <= n_out;
        end
    end

endmodule

[verif/tb.sv]
// Testbench for subcell_front_normal: directed table plus random items, checked by a predictor.
`timescale 1ns / 100ps

module tb;
    import sfn_pkg::*;

    typedef struct {
        t_in  d;
        bit   typed;
        t_out e;
    } row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    logic [31:0] solid_thr;
    logic [31:0] min_grad;
    t_out        front_q[$];
    int          errors;
    int          in_idle_pct;
    int          out_stall_pct;
    int          sent;

    subcell_front_normal i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [15:0] scale_comp(longint g, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (g < 0) ? longint'(-g) : longint'(g);
        q = (m * 64'd32768 + len) / (64'd2 * len);
        if (q > 64'd16384) q = 64'd16384;
        if (g < 0) q = 64'd0 - q;
        return q[15:0];
    endfunction

    function automatic t_out predict_front(t_in d);
        t_out r;
        longint dv[8];
        longint gx, gy, gz;
        logic [79:0] s, lim, c;
        logic [79:0] root;
        int cnt;
        dv[0] = d.density_0; dv[1] = d.density_1; dv[2] = d.density_2;
        dv[3] = d.density_3; dv[4] = d.density_4; dv[5] = d.density_5;
        dv[6] = d.density_6; dv[7] = d.density_7;
        cnt = 0;
        for (int u = 0; u < 8; u++) begin
            if (dv[u] > longint'(solid_thr)) cnt++;
        end
        r = '0;
        r.is_front = (cnt >= 1 && cnt <= 7);
        if (r.is_front) begin
            gx = (dv[1] + dv[3] + dv[5] + dv[7]) - (dv[0] + dv[2] + dv[4] + dv[6]);
            gy = (dv[2] + dv[3] + dv[6] + dv[7]) - (dv[0] + dv[1] + dv[4] + dv[5]);
            gz = (dv[4] + dv[5] + dv[6] + dv[7]) - (dv[0] + dv[1] + dv[2] + dv[3]);
            // squares of 35-bit values exceed 64 bits
            s = (80'(gx < 0 ? -gx : gx) * 80'(gx < 0 ? -gx : gx))
              + (80'(gy < 0 ? -gy : gy) * 80'(gy < 0 ? -gy : gy))
              + (80'(gz < 0 ? -gz : gz) * 80'(gz < 0 ? -gz : gz));
            lim = 80'(min_grad) * 80'(min_grad);
            if (s <= lim) begin
                r.normal_y = NML_ONE;
            end else begin
                root = '0;
                for (int b = 36; b >= 0; b--) begin
                    c = root | (80'd1 << b);
                    if (c * c <= s) root = c;
                end
                r.normal_x = scale_comp(gx, root[63:0]);
                r.normal_y = scale_comp(gy, root[63:0]);
                r.normal_z = scale_comp(gz, root[63:0]);
            end
        end
        r.front_x   = d.cell_x;
        r.front_y   = d.cell_y;
        r.front_z   = d.cell_z;
        r.front_sub = d.sub_index;
        return r;
    endfunction

    function automatic t_in mk_in(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                  logic [31:0] a3, logic [31:0] a4, logic [31:0] a5,
                                  logic [31:0] a6, logic [31:0] a7,
                                  logic [9:0] x, logic [9:0] y, logic [9:0] z,
                                  logic [2:0] sb);
        t_in d;
        d.density_0 = a0; d.density_1 = a1; d.density_2 = a2; d.density_3 = a3;
        d.density_4 = a4; d.density_5 = a5; d.density_6 = a6; d.density_7 = a7;
        d.cell_x = x; d.cell_y = y; d.cell_z = z; d.sub_index = sb;
        return d;
    endfunction

    function automatic t_out mk_out(logic f, logic [15:0] nx, logic [15:0] ny,
                                    logic [15:0] nz, t_in d);
        t_out r;
        r.is_front = f; r.normal_x = nx; r.normal_y = ny; r.normal_z = nz;
        r.front_x = d.cell_x; r.front_y = d.cell_y; r.front_z = d.cell_z;
        r.front_sub = d.sub_index;
        return r;
    endfunction

    function automatic logic [31:0] rand_density();
        longint v;
        case ($urandom % 8)
            0: return $urandom;
            1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            default: begin
                v = longint'(solid_thr) + $urandom_range(0, 8) - 4;
                if (v < 0) v = 0;
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
                return v[31:0];
            end
        endcase
    endfunction

    function automatic t_in rand_item();
        return mk_in(rand_density(), rand_density(), rand_density(), rand_density(),
                     rand_density(), rand_density(), rand_density(), rand_density(),
                     10'($urandom), 10'($urandom), 10'($urandom), 3'($urandom));
    endfunction

    task automatic set_idle();
        if (sent < 500) begin
            in_idle_pct = 31; out_stall_pct = 88;
        end else if (sent < 1000) begin
            in_idle_pct = 88; out_stall_pct = 31;
        end else begin
            in_idle_pct = 0; out_stall_pct = 0;
        end
    endtask

    task automatic send_item(t_in d, bit typed, t_out e);
        bit   acc;
        t_out want;
        set_idle();
        while (($urandom % 100) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do begin
            @(negedge i_clk);
            acc = o_in_ready;
            @(posedge i_clk);
        end while (!acc);
        want = typed ? e : predict_front(d);
        front_q = {front_q, want};
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (front_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic idx, logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        if (idx == CFG_SOLID) solid_thr = v;
        else min_grad = v;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= (($urandom % 100) >= out_stall_pct);
    end

    always @(negedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (front_q.size() == 0) begin
                $error("result with nothing expected: %p", o_out_data);
                errors++;
            end else begin
                e = front_q.pop_front();
                if (o_out_data.is_front !== e.is_front) begin
                    $error("is_front exp %0d got %0d", e.is_front, o_out_data.is_front);
                    errors++;
                end
                if (o_out_data.normal_x !== e.normal_x) begin
                    $error("normal_x exp %0d got %0d", e.normal_x, o_out_data.normal_x);
                    errors++;
                end
                if (o_out_data.normal_y !== e.normal_y) begin
                    $error("normal_y exp %0d got %0d", e.normal_y, o_out_data.normal_y);
                    errors++;
                end
                if (o_out_data.normal_z !== e.normal_z) begin
                    $error("normal_z exp %0d got %0d", e.normal_z, o_out_data.normal_z);
                    errors++;
                end
                if (o_out_data.front_x !== e.front_x) begin
                    $error("front_x exp %0d got %0d", e.front_x, o_out_data.front_x);
                    errors++;
                end
                if (o_out_data.front_y !== e.front_y) begin
                    $error("front_y exp %0d got %0d", e.front_y, o_out_data.front_y);
                    errors++;
                end
                if (o_out_data.front_z !== e.front_z) begin
                    $error("front_z exp %0d got %0d", e.front_z, o_out_data.front_z);
                    errors++;
                end
                if (o_out_data.front_sub !== e.front_sub) begin
                    $error("front_sub exp %0d got %0d", e.front_sub, o_out_data.front_sub);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        row_t rows[$];
        row_t rw;
        t_in  d;
        logic [31:0] thr_set[7];
        logic [31:0] min_set[7];
        localparam logic [31:0] MX = 32'hFFFF_FFFF;
        errors = 0;
        sent = 0;
        in_idle_pct = 31;
        out_stall_pct = 88;
        solid_thr = 32'd4;
        min_grad = 32'd0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SOLID;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing solid, all solid, all at threshold: not a front
        d = mk_in(0, 0, 0, 0, 0, 0, 0, 0, 10'h3FF, 10'h3FF, 10'h3FF, 3'd7);
        rw.d = d; rw.typed = 1'b1; rw.e = mk_out(1'b0, '0, '0, '0, d); rows = {rows, rw};
        d = mk_in(MX, MX, MX, MX, MX, MX, MX, MX, 10'd0, 10'd0, 10'd0, 3'd0);
        rw.d = d; rw.typed = 1'b1; rw.e = mk_out(1'b0, '0, '0, '0, d); rows = {rows, rw};
        d = mk_in(4, 4, 4, 4, 4, 4, 4, 4, 10'd1, 10'd2, 10'd3, 3'd4);
        rw.d = d; rw.typed = 1'b1; rw.e = mk_out(1'b0, '0, '0, '0, d); rows = {rows, rw};
        // zero gradient on a front: default normal
        d = mk_in(10, 0, 0, 0, 0, 0, 0, 10, 10'd5, 10'd6, 10'd7, 3'd1);
        rw.d = d; rw.typed = 1'b1; rw.e = mk_out(1'b1, '0, NML_ONE, '0, d);
        rows = {rows, rw};
        // single axis at full scale
        d = mk_in(MX, MX, MX, MX, 0, 0, 0, 0, 10'd9, 10'd9, 10'd9, 3'd2);
        rw.d = d; rw.typed = 1'b1; rw.e = mk_out(1'b1, '0, '0, -16'sd16384, d);
        rows = {rows, rw};
        d = mk_in(0, MX, 0, MX, 0, MX, 0, MX, 10'd8, 10'd8, 10'd8, 3'd3);
        rw.d = d; rw.typed = 1'b1; rw.e = mk_out(1'b1, NML_ONE, '0, '0, d);
        rows = {rows, rw};
        rw.typed = 1'b0;
        rw.d = mk_in(5, 0, 0, 0, 0, 0, 0, 0, 10'd0, 10'h3FF, 10'd0, 3'd5); rows = {rows, rw};
        rw.d = mk_in(0, 0, 0, 0, 0, 0, 0, MX, 10'h3FF, 10'd0, 10'd0, 3'd6); rows = {rows, rw};
        rw.d = mk_in(5, 4, 4, 4, 4, 4, 4, 4, 10'd0, 10'd0, 10'h3FF, 3'd0); rows = {rows, rw};
        rw.d = mk_in(MX, MX, MX, MX, MX, MX, MX, 0, 10'd1, 10'd1, 10'd1, 3'd1);
        rows = {rows, rw};
        rw.d = mk_in(0, MX, MX, 0, MX, 0, 0, MX, 10'd2, 10'd3, 10'd4, 3'd5);
        rows = {rows, rw};
        rw.d = mk_in(MX, 5, 0, 7, 0, 0, 100, 1, 10'd3, 10'd2, 10'd1, 3'd0);
        rows = {rows, rw};
        rw.d = mk_in(32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0, 10'h155, 10'h2AA,
                     10'h155, 3'd5); rows = {rows, rw};
        rw.d = mk_in(32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0, 0, 10'h2AA, 10'h155,
                     10'h2AA, 3'd2); rows = {rows, rw};
        foreach (rows[k]) send_item(rows[k].d, rows[k].typed, rows[k].e);
        drain();

        thr_set = '{32'd4, 32'd0, MX, $urandom, 32'h1000, $urandom, 32'h10000};
        min_set = '{32'd0, 32'd0, 32'd0, 32'd0, MX, $urandom % 32'h100000, 32'h800};
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_SOLID, thr_set[p]);
            write_reg(CFG_MIN, min_set[p]);
            i_cfg_we <= 1'b0;
            for (int n = 0; n < 215; n++) begin
                if (p == 3 && n == 100) begin
                    i_in_valid <= 1'b0;
                    while (front_q.size() != 0) @(posedge i_clk);
                end
                send_item(rand_item(), 0, '0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/sfn_pkg.sv
rtl/core/subcell_front_normal.sv
verif/tb.sv
